// File: rtl/b64e_pkg.sv
// b64e_pkg: shared types, constants and the sextet-to-character function
`timescale 1ns / 1ps

package b64e_pkg;

    // group phase codes
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // register map
    localparam int          APB_ADDR_W   = 3;
    localparam logic        REG_IDX_MODE = 1'b0;

    // ascii codes
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_DIGIT_0 = 7'h30;
    localparam logic [6:0] CH_PLUS    = 7'h2B;
    localparam logic [6:0] CH_SLASH   = 7'h2F;
    localparam logic [6:0] CH_MINUS   = 7'h2D;
    localparam logic [6:0] CH_UNDER   = 7'h5F;
    localparam logic [6:0] CH_PAD     = 7'h3D;

    // characters produced by one input byte, ready for the output side
    typedef struct packed {
        logic [3:0][6:0] chars;     // chars[0] goes out first
        logic [1:0]      last_idx;  // index of the last valid character
        logic            fin;       // bundle closes the message
    } t_bundle;

    // map a six-bit value onto the base64 alphabet
    function automatic logic [6:0] sextet_char(input logic [5:0] idx, input logic url);
        logic [6:0] c;
        priority if (idx < 6'd26) begin
            c = 7'(idx) + CH_UPPER_A;
        end else if (idx < 6'd52) begin
            c = 7'(idx - 6'd26) + CH_LOWER_A;
        end else if (idx < 6'd62) begin
            c = 7'(idx - 6'd52) + CH_DIGIT_0;
        end else if (idx == 6'd62) begin
            c = url ? CH_MINUS : CH_PLUS;
        end else begin
            c = url ? CH_UNDER : CH_SLASH;
        end
        return c;
    endfunction

endpackage

// File: rtl/b64e_encode.sv
// b64e_encode: group state and character bundle build for each input byte
`timescale 1ns / 1ps

module b64e_encode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    input  logic             i_url_safe,
    output logic             o_bundle_valid,
    output b64e_pkg::t_bundle o_bundle,
    input  logic             i_bundle_take
);
    import b64e_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic       r_buf_valid;
    t_bundle    r_buf, n_buf;
    logic       w_accept;

    // buffer frees up whenever the serialiser takes it this cycle
    assign o_ready        = !r_buf_valid || i_bundle_take;
    assign w_accept       = i_valid && o_ready;
    assign o_bundle_valid = r_buf_valid;
    assign o_bundle       = r_buf;

    // characters and next state for the byte on the input
    always_comb begin
        n_phase        = r_phase;
        n_carry        = r_carry;
        n_buf.chars    = '{default: CH_PAD};
        n_buf.last_idx = 2'd0;
        n_buf.fin      = i_final_byte;
        unique case (r_phase)
            PHASE_SECOND: begin
                n_buf.chars[0] = sextet_char({r_carry[1:0], i_data_byte[7:4]}, i_url_safe);
                if (i_final_byte) begin
                    n_buf.chars[1] = sextet_char({i_data_byte[3:0], 2'b00}, i_url_safe);
                    n_buf.last_idx = i_url_safe ? 2'd1 : 2'd2;
                end else begin
                    n_carry = i_data_byte[3:0];
                    n_phase = PHASE_THIRD;
                end
            end
            PHASE_THIRD: begin
                n_buf.chars[0] = sextet_char({r_carry, i_data_byte[7:6]}, i_url_safe);
                n_buf.chars[1] = sextet_char(i_data_byte[5:0], i_url_safe);
                n_buf.last_idx = 2'd1;
                n_carry        = 4'd0;
                n_phase        = PHASE_FIRST;
            end
            default: begin
                n_buf.chars[0] = sextet_char(i_data_byte[7:2], i_url_safe);
                if (i_final_byte) begin
                    n_buf.chars[1] = sextet_char({i_data_byte[1:0], 4'b0000}, i_url_safe);
                    n_buf.last_idx = i_url_safe ? 2'd1 : 2'd3;
                end else begin
                    n_carry = {2'b00, i_data_byte[1:0]};
                    n_phase = PHASE_SECOND;
                end
            end
        endcase
        if (i_final_byte) begin
            n_phase = PHASE_FIRST;
            n_carry = 4'd0;
        end
    end

    // group state and bundle buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_FIRST;
            r_carry     <= 4'd0;
            r_buf_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_carry <= n_carry;
            end
            if (w_accept) begin
                r_buf_valid <= 1'b1;
            end else if (i_bundle_take) begin
                r_buf_valid <= 1'b0;
            end
        end
    end

    // bundle payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buf <= n_buf;
        end
    end

endmodule

// File: rtl/b64e_serial.sv
// b64e_serial: sends the characters of each bundle one transfer at a time
`timescale 1ns / 1ps

module b64e_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_bundle_valid,
    input  b64e_pkg::t_bundle i_bundle,
    output logic              o_bundle_take,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [6:0]        o_char,
    output logic              o_last
);
    import b64e_pkg::*;

    logic       r_valid;
    t_bundle    r_cur;
    logic [1:0] r_idx;
    logic       w_at_end;
    logic       w_done;

    assign w_at_end      = (r_idx == r_cur.last_idx);
    assign w_done        = r_valid && i_ready && w_at_end;
    assign o_bundle_take = i_bundle_valid && (!r_valid || w_done);

    assign o_valid = r_valid;
    assign o_char  = r_cur.chars[r_idx];
    assign o_last  = r_cur.fin && w_at_end;

    // character index and bundle occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_bundle_take) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (w_done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // current bundle payload
    always_ff @(posedge i_clk) begin
        if (o_bundle_take) begin
            r_cur <= i_bundle;
        end
    end

endmodule

// File: rtl/base64_stream_encoder.sv
// base64_stream_encoder: top level with stream ports and the mode register
`timescale 1ns / 1ps

// Streaming Base64 encoder. One byte is taken per transfer on the slave side,
// tlast marking the final byte of a message; one ASCII character leaves per
// transfer on the master side, tlast on the last character of the message.
// The first and second byte of a group yield one character each, the third two,
// a final byte two to four; characters leave the single output channel one per
// cycle while m_axis_tready holds high, and then a byte whose characters fit the
// free output slot is taken every cycle. A byte passes the bundle buffer, then
// the serialiser register. Register 0 (address 0, bit 0) selects the URL-safe
// alphabet without padding; write it only while the encoder is idle.

module base64_stream_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  logic                            s_axis_tlast,   // final_byte
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic                            m_axis_tlast,   // end_of_text
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b64e_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import b64e_pkg::*;

    logic       r_url_safe;
    logic       w_bundle_valid;
    t_bundle    w_bundle;
    logic       w_bundle_take;
    logic [6:0] w_char;

    // register access
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_MODE) ? {31'd0, r_url_safe} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url_safe <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_ADDR_W-1] == REG_IDX_MODE) begin
            r_url_safe <= pwdata[0];
        end
    end

    // byte to character bundle
    b64e_encode u_encode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_data_byte    (s_axis_tdata),
        .i_final_byte   (s_axis_tlast),
        .i_url_safe     (r_url_safe),
        .o_bundle_valid (w_bundle_valid),
        .o_bundle       (w_bundle),
        .i_bundle_take  (w_bundle_take)
    );

    // bundle to character transfers
    b64e_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bundle_valid (w_bundle_valid),
        .i_bundle       (w_bundle),
        .o_bundle_take  (w_bundle_take),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_char         (w_char),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

endmodule

// File: rtl/b64e_checker.sv
// b64e_checker: port-level checks on the encoder, bound to the top level
`timescale 1ns / 1ps

module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       pready
);

    // reset leaves nothing to send
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // with the output side empty the input side must be open
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a stalled character holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transfer changed");

    // characters are seven-bit ascii and the register port never waits
    a_ascii_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && (!m_axis_tvalid || !m_axis_tdata[7]))
        else $error("non-ascii character or register port not ready");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
